// File: hdl/srbm_pkg.sv
// ----------------------------------------------------------------------------
// srbm_pkg
// Shared types, codes and constants of the serial report bridge monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package srbm_pkg;

  // Default geometry
  localparam int FRAME_BYTES_DEF = 8;
  localparam int BLINK_SHIFT_DEF = 16;

  // Fixed field widths
  localparam int REPORT_W = 64;
  localparam int BYTE_W   = 8;
  localparam int FAULT_W  = 3;
  localparam int LED_W    = 2;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register reset values
  localparam logic [7:0] MAGIC_MASK_RST     = 8'd255;
  localparam logic [7:0] MAGIC_VALUE_RST    = 8'd0;
  localparam logic [7:0] TX_FLAG_MASK_RST   = 8'd1;
  localparam logic [7:0] RX_FLAG_MASK_RST   = 8'd2;
  localparam logic [7:0] RESYNC_QUERY_RST   = 8'd255;
  localparam logic [7:0] REFRESH_PERIOD_RST = 8'd5;

  // Fault codes
  localparam logic [FAULT_W-1:0] FAULT_NONE    = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_MISSING = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_LATE    = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_STALL   = 3'd4;

  // LED patterns while blinking
  localparam logic [LED_W-1:0] LEDS_ON  = 2'b11;
  localparam logic [LED_W-1:0] LEDS_OFF = 2'b00;

  // Dark frames appended after the blink frames
  localparam logic [3:0] BLINK_WAIT_FRAMES = 4'd4;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_POLL = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_MAGIC_MASK     = 3'd0,
    REG_MAGIC_VALUE    = 3'd1,
    REG_TX_FLAG_MASK   = 3'd2,
    REG_RX_FLAG_MASK   = 3'd3,
    REG_RESYNC_QUERY   = 3'd4,
    REG_REFRESH_PERIOD = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [REPORT_W-1:0] report;
    logic                report_valid;
    logic                notify_ready;
    logic                resync_ack;
    logic                led_write;
    logic [LED_W-1:0]    leds;
    logic [FAULT_W-1:0]  fault_code;
  } res_t;

  // Byte i of the neutral frame; the last frame byte carries the magic value.
  function automatic logic [7:0] neutral_byte(input int idx, input int frame_bytes,
                                              input logic [7:0] magic);
    logic [7:0] b;
    if (idx == frame_bytes - 1) begin
      b = magic;
    end else begin
      case (idx)
        2:       b = 8'h08;
        3:       b = 8'd128;
        4:       b = 8'd128;
        5:       b = 8'd128;
        6:       b = 8'd128;
        default: b = 8'd0;
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/serial_report_bridge_monitor.sv
// ----------------------------------------------------------------------------
// serial_report_bridge_monitor
// Serial-to-report bridge: frames serial bytes, refreshes a host report on
// polls, watches for missing, late and stalled frames, blinks fault codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per accepted
//   edge: op selects serial byte, host poll or blink tick; byte_value goes
//   with a serial byte. Every request yields exactly one result on the
//   output channel (out_valid / out_stall): report word, flags, LEDs and
//   the current fault code.
//   An accepted request's result is registered in the output slot, or in
//   the skid slot if the output result is not taken at that edge. A request
//   is taken each cycle while in_stall is low; all the per-request work is a
//   single pass of small logic between state registers and result register.
//   The result side has an output register and a skid register, so a
//   request is still taken while one result waits on a stalled receiver;
//   in_stall rises only once both are occupied and drops the cycle after
//   the receiver takes a result.
//   Reset (synchronous, active high) loads the neutral frame as full,
//   clears the fault, the poll phase and the blink counter, empties the
//   result registers and restores register defaults.
//   Configuration goes through the APB-style port, register i at byte
//   address 4*i; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_report_bridge_monitor #(
  parameter int FRAME_BYTES = srbm_pkg::FRAME_BYTES_DEF,
  parameter int BLINK_SHIFT = srbm_pkg::BLINK_SHIFT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    op,
  input  wire logic [srbm_pkg::BYTE_W-1:0]   byte_value,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [srbm_pkg::REPORT_W-1:0]      report,
  output logic                               report_valid,
  output logic                               notify_ready,
  output logic                               resync_ack,
  output logic                               led_write,
  output logic [srbm_pkg::LED_W-1:0]         leds,
  output logic [srbm_pkg::FAULT_W-1:0]       fault_code,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srbm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [srbm_pkg::PDATA_W-1:0]  pwdata,
  output logic [srbm_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  import srbm_pkg::*;

  localparam int FILL_W  = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W   = $clog2(FRAME_BYTES);
  localparam int BLINK_W = BLINK_SHIFT + 4;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);
  localparam logic [FILL_W-1:0] FILL_NEAR = FILL_W'(FRAME_BYTES - 1);

  // Configuration registers
  logic [7:0] cmp_mask;
  logic [7:0] cmp_value;
  logic [7:0] tx_flag_mask;
  logic [7:0] rx_flag_mask;
  logic [7:0] resync_query_byte;
  logic [7:0] refresh_period;

  // Block state
  logic [7:0]          frame_store [FRAME_BYTES];
  logic [FILL_W-1:0]   frame_fill;
  logic [FILL_W-1:0]   previous_fill;
  logic [REPORT_W-1:0] report_word;
  logic [FAULT_W-1:0]  fault_state;
  logic [7:0]          poll_phase;
  logic [BLINK_W-1:0]  blink_ticks;

  logic [7:0]          frame_store_next [FRAME_BYTES];
  logic [FILL_W-1:0]   frame_fill_next;
  logic [FILL_W-1:0]   previous_fill_next;
  logic [REPORT_W-1:0] report_word_next;
  logic [FAULT_W-1:0]  fault_state_next;
  logic [7:0]          poll_phase_next;
  logic [BLINK_W-1:0]  blink_ticks_next;

  // Result registers: output slot plus skid slot
  res_t out_res;
  res_t skid_res;
  logic skid_valid;
  res_t res_next;

  logic in_accept;
  logic out_take;
  logic cfg_write;
  logic [2:0] cfg_idx;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[4:2];

  always_comb begin
    case (cfg_reg_t'(cfg_idx))
      REG_MAGIC_MASK:     prdata = PDATA_W'(cmp_mask);
      REG_MAGIC_VALUE:    prdata = PDATA_W'(cmp_value);
      REG_TX_FLAG_MASK:   prdata = PDATA_W'(tx_flag_mask);
      REG_RX_FLAG_MASK:   prdata = PDATA_W'(rx_flag_mask);
      REG_RESYNC_QUERY:   prdata = PDATA_W'(resync_query_byte);
      REG_REFRESH_PERIOD: prdata = PDATA_W'(refresh_period);
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Per-request update
  // --------------------------------------------------------------------------
  logic [REPORT_W-1:0] neutral_word;
  logic                report_neutral;
  logic [7:0]          magic_byte;
  logic [BLINK_W-1:0]  blink_inc;
  logic [3:0]          blink_frame;
  logic [3:0]          flash_limit;
  logic [3:0]          dark_limit;
  logic [7:0]          phase_inc;

  // Neutral report: frame bytes of the neutral frame, upper bytes zero
  always_comb begin
    neutral_word = '0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      neutral_word[8*i +: 8] = neutral_byte(i, FRAME_BYTES, cmp_value);
    end
  end

  // Report still neutral over the bytes a refresh would copy
  always_comb begin
    report_neutral = 1'b1;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      if (report_word[8*i +: 8] != neutral_byte(i, FRAME_BYTES, 8'd0)) begin
        report_neutral = 1'b0;
      end
    end
  end

  assign magic_byte  = frame_store[FRAME_BYTES-1];
  assign blink_inc   = blink_ticks + BLINK_W'(1);
  assign blink_frame = blink_inc[BLINK_W-1 -: 4];
  assign flash_limit = {fault_state, 1'b0};
  assign dark_limit  = flash_limit + BLINK_WAIT_FRAMES;
  assign phase_inc   = poll_phase + 8'd1;

  always_comb begin
    frame_store_next   = frame_store;
    frame_fill_next    = frame_fill;
    previous_fill_next = previous_fill;
    report_word_next   = report_word;
    fault_state_next   = fault_state;
    poll_phase_next    = poll_phase;
    blink_ticks_next   = blink_ticks;
    res_next           = '0;

    case (op_t'(op))
      OP_BYTE: begin
        if (frame_fill >= FILL_NEAR && byte_value == resync_query_byte) begin
          // resync query: reload neutral frame as full, clear the fault
          res_next.resync_ack = 1'b1;
          fault_state_next    = FAULT_NONE;
          for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_store_next[i] = neutral_byte(i, FRAME_BYTES, cmp_value);
          end
          frame_fill_next = FILL_FULL;
        end else if (frame_fill < FILL_FULL) begin
          for (int i = 0; i < FRAME_BYTES; i++) begin
            if (frame_fill[IDX_W-1:0] == IDX_W'(i)) begin
              frame_store_next[i] = byte_value;
            end
          end
          frame_fill_next = frame_fill + FILL_W'(1);
        end else if (fault_state == FAULT_NONE) begin
          // overrun while the frame is full
          fault_state_next = FAULT_STALL;
          report_word_next = neutral_word;
        end
      end

      OP_POLL: begin
        if (poll_phase == 8'd0 && fault_state == FAULT_NONE) begin
          if (frame_fill == FILL_FULL) begin
            if ((magic_byte & cmp_mask) == cmp_value) begin
              res_next.led_write    = 1'b1;
              res_next.leds         = {|(magic_byte & rx_flag_mask),
                                       |(magic_byte & tx_flag_mask)};
              res_next.notify_ready = 1'b1;
              // copy all but the magic byte; that report byte holds
              for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                report_word_next[8*i +: 8] = frame_store[i];
              end
              for (int i = 0; i < FRAME_BYTES; i++) begin
                frame_store_next[i] = 8'd0;
              end
              frame_fill_next = '0;
            end else begin
              fault_state_next = FAULT_MISSING;
              report_word_next = neutral_word;
            end
          end else if (!report_neutral) begin
            fault_state_next = (frame_fill == '0) ? FAULT_MISSING : FAULT_LATE;
            report_word_next = neutral_word;
          end else if (frame_fill != '0 && previous_fill == frame_fill) begin
            fault_state_next = FAULT_STALL;
            report_word_next = neutral_word;
          end
          previous_fill_next = frame_fill_next;
        end
        res_next.report_valid = 1'b1;
        res_next.report       = report_word_next;
        poll_phase_next       = (phase_inc == refresh_period) ? 8'd0 : phase_inc;
      end

      OP_TICK: begin
        if (fault_state != FAULT_NONE) begin
          blink_ticks_next = blink_inc;
          if (blink_frame < flash_limit) begin
            res_next.led_write = 1'b1;
            res_next.leds      = blink_frame[0] ? LEDS_OFF : LEDS_ON;
          end else if (blink_frame < dark_limit) begin
            res_next.led_write = 1'b1;
            res_next.leds      = LEDS_OFF;
          end else begin
            blink_ticks_next = '0;
          end
        end
      end

      default: begin
      end
    endcase

    res_next.fault_code = fault_state_next;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_mask          <= MAGIC_MASK_RST;
      cmp_value         <= MAGIC_VALUE_RST;
      tx_flag_mask      <= TX_FLAG_MASK_RST;
      rx_flag_mask      <= RX_FLAG_MASK_RST;
      resync_query_byte <= RESYNC_QUERY_RST;
      refresh_period    <= REFRESH_PERIOD_RST;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame_store[i] <= neutral_byte(i, FRAME_BYTES, MAGIC_VALUE_RST);
      end
      frame_fill    <= FILL_FULL;
      previous_fill <= '0;
      report_word   <= '0;
      fault_state   <= FAULT_NONE;
      poll_phase    <= 8'd0;
      blink_ticks   <= '0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_idx))
          REG_MAGIC_MASK:     cmp_mask          <= pwdata[7:0];
          REG_MAGIC_VALUE:    cmp_value         <= pwdata[7:0];
          REG_TX_FLAG_MASK:   tx_flag_mask      <= pwdata[7:0];
          REG_RX_FLAG_MASK:   rx_flag_mask      <= pwdata[7:0];
          REG_RESYNC_QUERY:   resync_query_byte <= pwdata[7:0];
          REG_REFRESH_PERIOD: refresh_period    <= pwdata[7:0];
          default: begin
          end
        endcase
      end

      if (in_accept) begin
        frame_store   <= frame_store_next;
        frame_fill    <= frame_fill_next;
        previous_fill <= previous_fill_next;
        report_word   <= report_word_next;
        fault_state   <= fault_state_next;
        poll_phase    <= poll_phase_next;
        blink_ticks   <= blink_ticks_next;
      end

      // Result slots: skid drains into the output slot first
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_accept) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_res <= skid_res;
      end
    end else if (in_accept) begin
      if (!out_valid || out_take) begin
        out_res <= res_next;
      end else begin
        skid_res <= res_next;
      end
    end
  end

  assign report       = out_res.report;
  assign report_valid = out_res.report_valid;
  assign notify_ready = out_res.notify_ready;
  assign resync_ack   = out_res.resync_ack;
  assign led_write    = out_res.led_write;
  assign leds         = out_res.leds;
  assign fault_code   = out_res.fault_code;

endmodule

`default_nettype wire
